### rtl/core/pcxr_pkg.sv
// pcxr_pkg: shared types, codes and sizing constants for the pcx rle palette decoder
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package pcxr_pkg;

    // sizing
    localparam int PALETTE_ENTRIES = 256;
    localparam int COUNTER_BITS    = 24;
    localparam int PAL_AW          = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam int POS_BITS        = 24;
    localparam int CMP_W           = (COUNTER_BITS > POS_BITS) ? COUNTER_BITS : POS_BITS;
    localparam int RUN_BITS        = 6;

    // largest value the pixel counter can hold, in comparison width
    localparam logic [CMP_W-1:0] CNT_MAX = CMP_W'((64'd1 << COUNTER_BITS) - 64'd1);

    // stream byte decoding
    localparam logic [7:0]          RUN_MARK = 8'hC0;
    localparam logic [RUN_BITS-1:0] RUN_MASK = 6'h3F;

    // item modes
    localparam logic [1:0] MODE_DATA = 2'd0;
    localparam logic [1:0] MODE_PAL  = 2'd1;
    localparam logic [1:0] MODE_NEW  = 2'd2;

    typedef logic [23:0] t_rgb;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic              en;
        logic [PAL_AW-1:0] addr;
        t_rgb              rgb;
    } t_pal_wr;

    typedef struct packed {
        logic              en;
        logic [PAL_AW-1:0] addr;
    } t_pal_rd;

endpackage

### rtl/core/pcx_rle_palette_decoder.sv
// pcx_rle_palette_decoder: pcx run-length decoder with 8-bit palette expansion to rgb
// top level; uses pcxr_pkg and pcxr_palette
// order: an accepted data byte registers its palette read and run count, then its pixels
//   enter the output register one pixel a cycle while the output slot frees up; one input
//   transaction per cycle for items that emit nothing, none taken while pixels are emitted
// reset: synchronous active low; clears the palette valid bits, run state, pixel
//   counter, image size and output valid at once, no clearing pass
`timescale 1ns / 1ps

module pcx_rle_palette_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: image size in pixels
    input  logic        i_cfg_we,
    input  logic [23:0] i_cfg_data,
    // input items
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_mode,
    input  logic [7:0]  i_data_byte,
    input  logic [7:0]  i_palette_index,
    input  logic [7:0]  i_palette_red,
    input  logic [7:0]  i_palette_green,
    input  logic [7:0]  i_palette_blue,
    // decoded pixels
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic [23:0] o_pixel_position,
    output logic        o_last_of_run
);
    import pcxr_pkg::*;

    // control state
    t_state                  r_state, n_state;
    logic [23:0]             r_img;
    logic                    r_run_pending;
    logic [RUN_BITS-1:0]     r_pending_count;
    logic [COUNTER_BITS-1:0] r_pix;
    logic [RUN_BITS-1:0]     r_count;
    logic                    r_inrange;
    logic                    r_out_valid;

    // output payload
    logic [7:0]              r_red, r_green, r_blue;
    logic [POS_BITS-1:0]     r_pos;
    logic                    r_last;

    // derived
    logic                    accept;
    logic                    load_out;
    logic [CMP_W-1:0]        img_ext;
    logic [CMP_W-1:0]        size;
    logic [CMP_W-1:0]        pix_ext;
    logic [CMP_W-1:0]        remain;
    logic                    is_marker;
    logic [RUN_BITS-1:0]     raw_count;
    logic [RUN_BITS-1:0]     emit_count;
    logic                    byte_inrange;
    logic                    pal_inrange;
    t_pal_wr                 pal_wr;
    t_pal_rd                 pal_rd;
    t_rgb                    pal_rgb;
    t_rgb                    pix_rgb;

    pcxr_palette u_palette (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (pal_wr),
        .i_rd    (pal_rd),
        .o_rgb   (pal_rgb)
    );

    assign accept = i_valid && o_ready;

    // usable image size is clamped to what the counter can hold
    assign img_ext = CMP_W'(r_img);
    assign size    = (img_ext > CNT_MAX) ? CNT_MAX : img_ext;
    assign pix_ext = CMP_W'(r_pix);
    assign remain  = (pix_ext < size) ? (size - pix_ext) : '0;

    // byte parsing: a pending run takes priority over marker detection
    assign is_marker = ((i_data_byte & RUN_MARK) == RUN_MARK);
    always_comb begin
        raw_count = RUN_BITS'(1);
        if (r_run_pending) begin
            raw_count = r_pending_count;
        end
    end
    // pixels that would run past the image end are dropped
    assign emit_count = (CMP_W'(raw_count) > remain) ? remain[RUN_BITS-1:0] : raw_count;

    // indices past the table read as black and are never written
    assign byte_inrange = ({1'b0, i_data_byte} < 9'(PALETTE_ENTRIES));
    assign pal_inrange  = ({1'b0, i_palette_index} < 9'(PALETTE_ENTRIES));

    // palette write on a palette transaction, read on every accepted data byte
    always_comb begin
        pal_wr.en   = accept && (i_mode == MODE_PAL) && pal_inrange;
        pal_wr.addr = i_palette_index[PAL_AW-1:0];
        pal_wr.rgb  = {i_palette_red, i_palette_green, i_palette_blue};
        pal_rd.en   = accept && (i_mode == MODE_DATA);
        pal_rd.addr = i_data_byte[PAL_AW-1:0];
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && (i_mode == MODE_DATA) && (r_run_pending || !is_marker)
                    && (emit_count != '0)) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (load_out && (r_count == RUN_BITS'(1))) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs: take items only when idle, emit when the output slot frees up
    always_comb begin
        o_ready  = 1'b0;
        load_out = 1'b0;
        unique case (r_state)
            ST_IDLE: o_ready  = 1'b1;
            ST_EMIT: load_out = !r_out_valid || i_ready;
            default: begin
                o_ready  = 1'b0;
                load_out = 1'b0;
            end
        endcase
    end

    assign pix_rgb = r_inrange ? pal_rgb : '0;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_img           <= '0;
            r_run_pending   <= 1'b0;
            r_pending_count <= '0;
            r_pix           <= '0;
            r_count         <= '0;
            r_inrange       <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_img <= i_cfg_data;
            end
            if (accept) begin
                priority case (i_mode)
                    MODE_NEW: begin
                        r_pix           <= '0;
                        r_run_pending   <= 1'b0;
                        r_pending_count <= '0;
                    end
                    MODE_DATA: begin
                        if (r_run_pending) begin
                            r_run_pending   <= 1'b0;
                            r_pending_count <= '0;
                        end else if (is_marker) begin
                            // marker arms a run for the next byte
                            r_run_pending   <= 1'b1;
                            r_pending_count <= i_data_byte[RUN_BITS-1:0] & RUN_MASK;
                        end
                        r_count   <= emit_count;
                        r_inrange <= byte_inrange;
                    end
                    default: begin
                        // palette writes go straight to memory, mode 3 is ignored
                    end
                endcase
            end
            if (load_out) begin
                r_count <= r_count - RUN_BITS'(1);
                r_pix   <= r_pix + COUNTER_BITS'(1);
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // output payload register
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_red   <= pix_rgb[23:16];
            r_green <= pix_rgb[15:8];
            r_blue  <= pix_rgb[7:0];
            r_pos   <= pix_ext[POS_BITS-1:0];
            r_last  <= (r_count == RUN_BITS'(1));
        end
    end

    assign o_valid          = r_out_valid;
    assign o_red            = r_red;
    assign o_green          = r_green;
    assign o_blue           = r_blue;
    assign o_pixel_position = r_pos;
    assign o_last_of_run    = r_last;

endmodule

### rtl/core/pcxr_palette.sv
// pcxr_palette: colour table memory, one write and one registered read port
// per-entry valid bits make unwritten entries read as black; uses pcxr_pkg
`timescale 1ns / 1ps

module pcxr_palette (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  pcxr_pkg::t_pal_wr i_wr,
    input  pcxr_pkg::t_pal_rd i_rd,
    output pcxr_pkg::t_rgb   o_rgb
);
    import pcxr_pkg::*;

    t_rgb                       r_mem [PALETTE_ENTRIES];
    logic [PALETTE_ENTRIES-1:0] r_valid;
    t_rgb                       r_rdata;
    logic                       r_rvalid;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.rgb;
        end
        if (i_rd.en) begin
            r_rdata <= r_mem[i_rd.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rvalid <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_valid[i_wr.addr] <= 1'b1;
            end
            if (i_rd.en) begin
                r_rvalid <= r_valid[i_rd.addr];
            end
        end
    end

    // entries never written since reset read as zero
    assign o_rgb = r_rvalid ? r_rdata : '0;

endmodule
